// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/aro_pkg.sv =====
// Package of types and codes for the address range overlap table.
package aro_pkg;

  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_RESIZE     = 2'd2;
  localparam logic [1:0] OP_QUERY      = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_ARG  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [31:0] ID_FIRST = 32'd1;
  localparam logic [31:0] ID_LAST  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] range_id;
    logic [63:0] range_base;
    logic [63:0] range_size;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic        overlap_found;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] base;
    logic [63:0] size;
  } entry_t;

  // End of a range, saturated at the top address.
  function automatic logic [63:0] sat_end(input logic [63:0] base, input logic [63:0] size);
    logic [64:0] sum;
    sum = {1'b0, base} + {1'b0, size};
    return sum[64] ? {64{1'b1}} : sum[63:0];
  endfunction

endpackage

// ===== rtl/aro_stream_if.sv =====
// Valid/ready stream interface carrying one item of a chosen payload type.
interface aro_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/address_range_overlap_table_top.sv =====
// Address range overlap table: range store in a one-port-read memory, walked per item.
//
// The block keeps up to ENTRIES address ranges (id, base, size) in a synchronous
// memory, with one valid bit per entry in flip-flops that reset clears. Every
// register, unregister, resize or overlap query item that is not rejected for a
// zero argument walks the memory one entry per cycle through its single read
// port, lowest index first, and stops at the first entry that answers the item:
// the first free slot for a register, the first valid entry with the given id
// for unregister and resize, the first valid overlapping range for a query. An
// early hit ends the walk sooner. An item rejected for a zero argument skips
// the walk and moves into the output register once that register is free, and
// the next item can be taken after that.
// One item is worked on at a time, and the next one is accepted while a result
// still waits in the output register. Ids count up from one and skip zero on
// wrap; range ends saturate at the top address and a zero size never overlaps.
module address_range_overlap_table_top #(
  parameter int ENTRIES = aro_pkg::ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  aro_stream_if.sink        req,
  aro_stream_if.source      rsp
);
  import aro_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;

  // The item under work, held from acceptance to completion.
  logic [1:0]  q_op;
  logic [31:0] q_id;
  logic [63:0] q_base;
  logic [63:0] q_size;
  logic [63:0] q_end;

  // Result waiting to move into the output register.
  logic [1:0]  res_status;
  logic [31:0] res_id;
  logic        res_hit;

  logic [ENTRIES-1:0] valid;
  logic [31:0]        next_id;

  // Range store and its registered read.
  entry_t        mem [ENTRIES];
  entry_t        rd_data;
  logic [IW-1:0] rd_idx;
  logic          rd_vld;
  logic [IW-1:0] issue_idx;
  logic          issuing;

  logic          mem_we;
  entry_t        mem_wdata;

  logic          out_valid;
  rsp_item_t     out_data;

  logic          accept;
  logic          out_free;
  logic          entry_hit;
  logic          finish;
  logic [63:0]   ent_end;
  logic          meet;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Compare stage: the entry read in the previous cycle against the item.
  always_comb begin
    ent_end = sat_end(rd_data.base, rd_data.size);
    meet = (q_size != 64'd0) && (rd_data.size != 64'd0) &&
           (q_base < ent_end) && (rd_data.base < q_end);
    case (q_op)
      OP_REGISTER:   entry_hit = !valid[rd_idx];
      OP_UNREGISTER: entry_hit = valid[rd_idx] && (rd_data.id == q_id);
      OP_RESIZE:     entry_hit = valid[rd_idx] && (rd_data.id == q_id);
      default:       entry_hit = valid[rd_idx] && meet;
    endcase
    finish = (state == S_SCAN) && rd_vld && (entry_hit || (rd_idx == LAST_IDX));
  end

  // Memory write on a successful register or resize.
  always_comb begin
    mem_we    = finish && entry_hit && ((q_op == OP_REGISTER) || (q_op == OP_RESIZE));
    mem_wdata = '{id: (q_op == OP_REGISTER) ? next_id : q_id, base: q_base, size: q_size};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rd_idx] <= mem_wdata;
    end
    if ((state == S_SCAN) && issuing) begin
      rd_data <= mem[issue_idx];
      rd_idx  <= issue_idx;
    end
  end

  // Control: accept, walk, finish, hand over to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
      valid     <= '0;
      next_id   <= ID_FIRST;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_op       <= req.data.opcode;
            q_id       <= req.data.range_id;
            q_base     <= req.data.range_base;
            q_size     <= req.data.range_size;
            q_end      <= sat_end(req.data.range_base, req.data.range_size);
            res_status <= ST_ZERO_ARG;
            res_id     <= 32'd0;
            res_hit    <= 1'b0;
            issue_idx  <= '0;
            rd_vld     <= 1'b0;
            if (((req.data.opcode == OP_REGISTER) &&
                 ((req.data.range_base == 64'd0) || (req.data.range_size == 64'd0))) ||
                ((req.data.opcode == OP_UNREGISTER) && (req.data.range_id == 32'd0))) begin
              state <= S_FIN;
            end else begin
              state   <= S_SCAN;
              issuing <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (finish) begin
            issuing <= 1'b0;
            rd_vld  <= 1'b0;
            state   <= S_FIN;
            case (q_op)
              OP_REGISTER: begin
                if (entry_hit) begin
                  res_status    <= ST_OK;
                  res_id        <= next_id;
                  valid[rd_idx] <= 1'b1;
                  next_id       <= (next_id == ID_LAST) ? ID_FIRST : next_id + 32'd1;
                end else begin
                  res_status <= ST_FULL;
                end
              end
              OP_UNREGISTER: begin
                if (entry_hit) begin
                  res_status    <= ST_OK;
                  valid[rd_idx] <= 1'b0;
                end else begin
                  res_status <= ST_NOT_FOUND;
                end
              end
              OP_RESIZE: begin
                res_status <= entry_hit ? ST_OK : ST_NOT_FOUND;
              end
              default: begin
                res_status <= ST_OK;
                res_hit    <= entry_hit;
              end
            endcase
          end else begin
            if (issuing) begin
              issue_idx <= issue_idx + IW'(1);
              if (issue_idx == LAST_IDX) begin
                issuing <= 1'b0;
              end
            end
            rd_vld <= issuing;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded with a finished result once it is free, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
      out_data  <= '{status: res_status, assigned_id: res_id, overlap_found: res_hit};
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // A read result is only ever pending while the walk is running.
  `ASSERT_SAME(a_rd_in_scan, clk, rst, rd_vld, state == S_SCAN)
  // An accepted item always leaves the idle state.
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != S_IDLE)
  // A finished result reaches the output as soon as the output is free.
  `ASSERT_NEXT(a_fin_out, clk, rst, (state == S_FIN) && out_free, rsp.valid)
  // Id zero is never handed out.
  `ASSERT_SAME(a_id_nonzero, clk, rst, 1'b1, next_id != 32'd0)

endmodule
